### rtl/core/tga_rle_pixel_decoder_assert.svh
// assertion macros shared by the tga rle decoder rtl
// expects clk and rst in the scope of each use
`ifndef TGA_RLE_PIXEL_DECODER_ASSERT_SVH
`define TGA_RLE_PIXEL_DECODER_ASSERT_SVH

// same-cycle implication
`define TGA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TGA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/tga_dec_pkg.sv
// shared types, register indexes and helpers for the tga rle decoder
// no dependencies
package tga_dec_pkg;

  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_RLE_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd3;

  localparam logic [2:0] BPP_GREY = 3'd1;
  localparam logic [2:0] BPP_RGB  = 3'd3;
  localparam logic [2:0] BPP_RGBA = 3'd4;

  localparam logic [6:0] PKT_COUNT_MASK = 7'h7F;
  localparam int         PKT_REPEAT_BIT = 7;

  typedef struct packed {
    logic [31:0] colour;
    logic [7:0]  count;
    logic        last;
    logic [2:0]  bpp;
  } pix_rec_t;

  function automatic logic [2:0] eff_bpp(input logic [2:0] raw);
    logic [2:0] res;
    if (raw == BPP_RGB) begin
      res = BPP_RGB;
    end else if (raw >= BPP_RGBA) begin
      res = BPP_RGBA;
    end else begin
      res = BPP_GREY;
    end
    return res;
  endfunction

  function automatic logic [15:0] eff_dim(input logic [15:0] raw);
    return (raw == 16'd0) ? 16'd1 : raw;
  endfunction

endpackage

### rtl/core/tga_rle_pixel_decoder.sv
// TGA image-data decoder: takes one stream byte per cycle (plain or run-length packets,
// 1, 3 or 4 bytes per pixel) and returns RGB(A) pixels with a repeat count, flagging the
// pixel that completes the image. A byte is taken every cycle while the output side keeps
// up; a pixel's record is written into the record queue when its last byte is accepted,
// and moves from there into the output register. When the output stalls, the queue
// absorbs up to QUEUE_DEPTH pixels behind the one held on the output before the input is
// held off, and once the queue has filled the input resumes in the cycle after the output
// moves again. Width and height writes take effect from the next image.
// depends on tga_dec_pkg, tga_dec_front, tga_dec_queue, tga_dec_back
module tga_rle_pixel_decoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write_en,
  input  logic [tga_dec_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tga_dec_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        stream_byte,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [7:0]                        red,
  output logic [7:0]                        green,
  output logic [7:0]                        blue,
  output logic [7:0]                        alpha,
  output logic [7:0]                        repeat_count,
  output logic                              last_of_image
);

  logic                  push;
  tga_dec_pkg::pix_rec_t push_rec;
  logic                  space;
  logic                  head_valid;
  tga_dec_pkg::pix_rec_t head_rec;
  logic                  take;

  tga_dec_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .byte_valid   (in_valid),
    .byte_ready   (in_ready),
    .stream_byte  (stream_byte),
    .rec_valid    (push),
    .rec          (push_rec),
    .rec_space    (space)
  );

  tga_dec_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_rec   (push_rec),
    .space      (space),
    .head_valid (head_valid),
    .head_rec   (head_rec),
    .pop        (take)
  );

  tga_dec_back u_back (
    .clk           (clk),
    .rst           (rst),
    .rec_valid     (head_valid),
    .rec           (head_rec),
    .rec_take      (take),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .alpha         (alpha),
    .repeat_count  (repeat_count),
    .last_of_image (last_of_image)
  );

endmodule

### rtl/core/tga_dec_front.sv
// front end: config registers, packet header parsing, pixel assembly, count clipping
// depends on tga_dec_pkg and tga_rle_pixel_decoder_assert.svh
`include "tga_rle_pixel_decoder_assert.svh"

module tga_dec_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write_en,
  input  logic [tga_dec_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tga_dec_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                              byte_valid,
  output logic                              byte_ready,
  input  logic [7:0]                        stream_byte,
  output logic                              rec_valid,
  output tga_dec_pkg::pix_rec_t             rec,
  input  logic                              rec_space
);

  logic        rle_mode;
  logic [2:0]  bpp_reg;
  logic [15:0] width_reg;
  logic [15:0] height_reg;
  logic [31:0] area;

  logic [31:0] pixels_left;
  logic        expect_header;
  logic        packet_repeats;
  logic [7:0]  packet_pixels_left;
  logic [1:0]  component_index;
  logic [31:0] colour_assembly;

  logic [15:0] mul_a;
  logic [15:0] mul_b;
  logic [31:0] area_next;

  logic        accept;
  logic        start;
  logic [31:0] pl_cur;
  logic        eh_cur;
  logic [7:0]  ppl_cur;
  logic [1:0]  ci_cur;
  logic [2:0]  bpp_eff;
  logic        is_header;
  logic [31:0] colour_next;
  logic [2:0]  ci_inc;
  logic        complete;
  logic        repeat_pkt;
  logic [7:0]  clipped;
  logic [7:0]  count;
  logic [7:0]  ppl_after;
  logic [31:0] pixels_left_next;
  logic        last;
  logic        expect_header_next;
  logic [7:0]  packet_pixels_left_next;

  // pixel area for a new image, updated with the write itself
  always_comb begin
    mul_a = (cfg_index == tga_dec_pkg::REG_IMAGE_WIDTH) ?
            tga_dec_pkg::eff_dim(cfg_data) : tga_dec_pkg::eff_dim(width_reg);
    mul_b = (cfg_index == tga_dec_pkg::REG_IMAGE_HEIGHT) ?
            tga_dec_pkg::eff_dim(cfg_data) : tga_dec_pkg::eff_dim(height_reg);
    area_next = {16'd0, mul_a} * {16'd0, mul_b};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rle_mode   <= 1'b0;
      bpp_reg    <= tga_dec_pkg::BPP_RGB;
      width_reg  <= 16'd1;
      height_reg <= 16'd1;
      area       <= 32'd1;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        tga_dec_pkg::REG_RLE_MODE: begin
          rle_mode <= cfg_data[0];
        end
        tga_dec_pkg::REG_BYTES_PER_PX: begin
          bpp_reg <= cfg_data[2:0];
        end
        tga_dec_pkg::REG_IMAGE_WIDTH: begin
          width_reg <= cfg_data;
          area      <= area_next;
        end
        tga_dec_pkg::REG_IMAGE_HEIGHT: begin
          height_reg <= cfg_data;
          area       <= area_next;
        end
        default: begin
        end
      endcase
    end
  end

  assign byte_ready = rec_space;
  assign accept     = byte_valid && rec_space;

  always_comb begin
    start      = (pixels_left == 32'd0);
    pl_cur     = start ? area : pixels_left;
    eh_cur     = start | expect_header;
    ppl_cur    = start ? 8'd0 : packet_pixels_left;
    ci_cur     = start ? 2'd0 : component_index;
    bpp_eff    = tga_dec_pkg::eff_bpp(bpp_reg);
    is_header  = rle_mode && eh_cur;

    colour_next = colour_assembly;
    unique case (ci_cur)
      2'd0: colour_next[7:0]   = stream_byte;
      2'd1: colour_next[15:8]  = stream_byte;
      2'd2: colour_next[23:16] = stream_byte;
      2'd3: colour_next[31:24] = stream_byte;
    endcase

    ci_inc     = {1'b0, ci_cur} + 3'd1;
    complete   = !is_header && (ci_inc >= bpp_eff);
    repeat_pkt = rle_mode && packet_repeats;

    // repeated packets are cut to what the image still owes
    clipped = (pl_cur < {24'd0, ppl_cur}) ? pl_cur[7:0] : ppl_cur;
    if (repeat_pkt) begin
      count     = (clipped == 8'd0) ? 8'd1 : clipped;
      ppl_after = 8'd0;
    end else begin
      count     = 8'd1;
      ppl_after = (rle_mode && ppl_cur != 8'd0) ? ppl_cur - 8'd1 : ppl_cur;
    end

    pixels_left_next        = pl_cur - {24'd0, count};
    last                    = (pixels_left_next == 32'd0);
    expect_header_next      = eh_cur | last | (rle_mode && ppl_after == 8'd0);
    packet_pixels_left_next = last ? 8'd0 : ppl_after;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixels_left        <= 32'd0;
      expect_header      <= 1'b1;
      packet_repeats     <= 1'b0;
      packet_pixels_left <= 8'd0;
      component_index    <= 2'd0;
      colour_assembly    <= 32'd0;
    end else if (accept) begin
      if (is_header) begin
        packet_repeats     <= stream_byte[tga_dec_pkg::PKT_REPEAT_BIT];
        packet_pixels_left <= {1'b0, stream_byte[6:0] & tga_dec_pkg::PKT_COUNT_MASK} + 8'd1;
        expect_header      <= 1'b0;
        component_index    <= 2'd0;
        pixels_left        <= pl_cur;
      end else if (!complete) begin
        colour_assembly    <= colour_next;
        component_index    <= ci_inc[1:0];
        pixels_left        <= pl_cur;
        expect_header      <= eh_cur;
        packet_pixels_left <= ppl_cur;
      end else begin
        colour_assembly    <= colour_next;
        component_index    <= 2'd0;
        pixels_left        <= pixels_left_next;
        expect_header      <= expect_header_next;
        packet_pixels_left <= packet_pixels_left_next;
      end
    end
  end

  assign rec_valid = accept && complete;
  assign rec       = {colour_next, count, last, bpp_eff};

  `TGA_ASSERT_NOW(a_count_range, rec_valid, rec.count != 8'd0 && rec.count <= 8'd128,
    "repeat count out of range")
  `TGA_ASSERT_NEXT(a_last_clears, rec_valid && rec.last,
    pixels_left == 32'd0 && expect_header, "last pixel did not close the image")
  `TGA_ASSERT_NOW(a_header_silent, accept && is_header, !rec_valid,
    "packet header produced a pixel")

endmodule

### rtl/core/tga_dec_queue.sv
// short queue of decoded pixel records between the front end and the output stage
// depends on tga_dec_pkg and tga_rle_pixel_decoder_assert.svh
`include "tga_rle_pixel_decoder_assert.svh"

module tga_dec_queue #(
  parameter int DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  tga_dec_pkg::pix_rec_t push_rec,
  output logic                  space,
  output logic                  head_valid,
  output tga_dec_pkg::pix_rec_t head_rec,
  input  logic                  pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  tga_dec_pkg::pix_rec_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_pop;

  assign space      = (fill != FULL_CNT);
  assign head_valid = (fill != '0);
  assign head_rec   = slots[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !do_pop) begin
        fill <= fill + CNT_W'(1);
      end else if (!push && do_pop) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

  `TGA_ASSERT_NOW(a_no_overflow, push, space || pop, "push into a full queue")

endmodule

### rtl/core/tga_dec_back.sv
// output stage: bgr(a) to rgb(a) reorder and the registered result port
// depends on tga_dec_pkg
module tga_dec_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  rec_valid,
  input  tga_dec_pkg::pix_rec_t rec,
  output logic                  rec_take,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            red,
  output logic [7:0]            green,
  output logic [7:0]            blue,
  output logic [7:0]            alpha,
  output logic [7:0]            repeat_count,
  output logic                  last_of_image
);

  logic [7:0] red_next;
  logic [7:0] green_next;
  logic [7:0] blue_next;
  logic [7:0] alpha_next;
  logic       load;

  assign load     = rec_valid && (!out_valid || out_ready);
  assign rec_take = load;

  always_comb begin
    if (rec.bpp == tga_dec_pkg::BPP_GREY) begin
      red_next   = rec.colour[7:0];
      green_next = 8'd0;
      blue_next  = 8'd0;
      alpha_next = 8'd0;
    end else begin
      red_next   = rec.colour[23:16];
      green_next = rec.colour[15:8];
      blue_next  = rec.colour[7:0];
      alpha_next = (rec.bpp == tga_dec_pkg::BPP_RGBA) ? rec.colour[31:24] : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      red           <= red_next;
      green         <= green_next;
      blue          <= blue_next;
      alpha         <= alpha_next;
      repeat_count  <= rec.count;
      last_of_image <= rec.last;
    end
  end

endmodule

### dv/tga_rle_pixel_decoder_tb.sv
`timescale 1ns / 100ps
// testbench for tga_rle_pixel_decoder: feeds image-data byte streams and checks every pixel
// record against an in-bench decoder model; depends on tga_dec_pkg and the decoder rtl
module tga_rle_pixel_decoder_tb;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 6;
  localparam int IDLE_PCT      = 28;
  localparam int PHASE_BYTES   = 60;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] count;
    logic       last;
  } pixel_rec_t;

  logic                               clk;
  logic                               rst          = 1'b1;
  logic                               cfg_write_en = 1'b0;
  logic [tga_dec_pkg::CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [tga_dec_pkg::CFG_DATA_W-1:0] cfg_data     = '0;
  logic                               in_valid     = 1'b0;
  logic                               in_ready;
  logic [7:0]                         stream_byte  = '0;
  logic                               out_valid;
  logic                               out_ready    = 1'b0;
  logic [7:0]                         red;
  logic [7:0]                         green;
  logic [7:0]                         blue;
  logic [7:0]                         alpha;
  logic [7:0]                         repeat_count;
  logic                               last_of_image;

  // register shadow
  logic        rle_on;
  logic [2:0]  bpp_raw;
  logic [15:0] img_w;
  logic [15:0] img_h;

  // decoder state
  logic [31:0] img_pixels_left;
  logic        want_header;
  logic        run_packet;
  logic [7:0]  pkt_left;
  logic [1:0]  comp_idx;
  logic [31:0] colour_acc;

  pixel_rec_t expected_pixels[$];
  int         mismatches     = 0;
  int         bytes_sent     = 0;
  int         pixels_checked = 0;
  int         cycle_count    = 0;
  bit         steady         = 1'b0;

  tga_rle_pixel_decoder u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .stream_byte  (stream_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .alpha        (alpha),
    .repeat_count (repeat_count),
    .last_of_image(last_of_image)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels outstanding", cycle_count,
               expected_pixels.size());
      $display("status: fail");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic reset_model();
    rle_on          = 1'b0;
    bpp_raw         = tga_dec_pkg::BPP_RGB;
    img_w           = 16'd1;
    img_h           = 16'd1;
    img_pixels_left = '0;
    want_header     = 1'b1;
    run_packet      = 1'b0;
    pkt_left        = '0;
    comp_idx        = '0;
    colour_acc      = '0;
  endtask

  // advance the decoder model by one accepted byte
  task automatic decode_byte(input logic [7:0] b);
    int          nbytes;
    logic [31:0] cnt;
    logic [31:0] w;
    logic [31:0] h;
    pixel_rec_t  px;
    nbytes = (bpp_raw == tga_dec_pkg::BPP_RGB) ? 3 :
             ((bpp_raw >= tga_dec_pkg::BPP_RGBA) ? 4 : 1);
    if (img_pixels_left == 0) begin
      w = (img_w == 0) ? 32'd1 : 32'(img_w);
      h = (img_h == 0) ? 32'd1 : 32'(img_h);
      img_pixels_left = w * h;
      want_header     = 1'b1;
      pkt_left        = '0;
      comp_idx        = '0;
    end
    if (rle_on && want_header) begin
      run_packet  = b[tga_dec_pkg::PKT_REPEAT_BIT];
      pkt_left    = {1'b0, b[6:0] & tga_dec_pkg::PKT_COUNT_MASK} + 8'd1;
      want_header = 1'b0;
      comp_idx    = '0;
    end else begin
      colour_acc[comp_idx*8 +: 8] = b;
      if (int'(comp_idx) + 1 < nbytes) begin
        comp_idx = comp_idx + 2'd1;
      end else begin
        comp_idx = '0;
        if (rle_on && run_packet) begin
          cnt = 32'(pkt_left);
          if (cnt > img_pixels_left) cnt = img_pixels_left;
          if (cnt == 0) cnt = 32'd1;
          pkt_left = '0;
        end else begin
          cnt = 32'd1;
          if (rle_on && pkt_left > 0) pkt_left = pkt_left - 8'd1;
        end
        img_pixels_left = img_pixels_left - cnt;
        if (rle_on && pkt_left == 0) want_header = 1'b1;
        px.last = (img_pixels_left == 0);
        if (px.last) begin
          pkt_left    = '0;
          want_header = 1'b1;
        end
        if (nbytes == 1) begin
          px.red   = colour_acc[7:0];
          px.green = '0;
          px.blue  = '0;
          px.alpha = '0;
        end else begin
          px.red   = colour_acc[23:16];
          px.green = colour_acc[15:8];
          px.blue  = colour_acc[7:0];
          px.alpha = (nbytes == 4) ? colour_acc[31:24] : 8'd0;
        end
        px.count = cnt[7:0];
        expected_pixels.push_back(px);
      end
    end
  endtask

  // output side: random stalls and per-transaction compare
  always @(posedge clk) begin
    pixel_rec_t px;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        pixels_checked++;
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("pixel r=%h g=%h b=%h with none expected", red, green, blue));
        end else begin
          px = expected_pixels.pop_front();
          if (red !== px.red)
            report_mismatch($sformatf("red %h, expected %h", red, px.red));
          if (green !== px.green)
            report_mismatch($sformatf("green %h, expected %h", green, px.green));
          if (blue !== px.blue)
            report_mismatch($sformatf("blue %h, expected %h", blue, px.blue));
          if (alpha !== px.alpha)
            report_mismatch($sformatf("alpha %h, expected %h", alpha, px.alpha));
          if (repeat_count !== px.count)
            report_mismatch($sformatf("repeat_count %0d, expected %0d", repeat_count, px.count));
          if (last_of_image !== px.last)
            report_mismatch($sformatf("last_of_image %b, expected %b", last_of_image, px.last));
        end
      end
      out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    stream_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    decode_byte(b);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(input logic rle, input logic [2:0] bpp,
                            input logic [15:0] w, input logic [15:0] h);
    wait_drained();
    for (int i = 0; i < 4; i++) begin
      cfg_write_en <= 1'b1;
      case (i)
        0: begin
          cfg_index <= tga_dec_pkg::REG_RLE_MODE;
          cfg_data  <= tga_dec_pkg::CFG_DATA_W'(rle);
        end
        1: begin
          cfg_index <= tga_dec_pkg::REG_BYTES_PER_PX;
          cfg_data  <= tga_dec_pkg::CFG_DATA_W'(bpp);
        end
        2: begin
          cfg_index <= tga_dec_pkg::REG_IMAGE_WIDTH;
          cfg_data  <= w;
        end
        default: begin
          cfg_index <= tga_dec_pkg::REG_IMAGE_HEIGHT;
          cfg_data  <= h;
        end
      endcase
      @(posedge clk);
    end
    cfg_write_en <= 1'b0;
    rle_on  = rle;
    bpp_raw = bpp;
    img_w   = w;
    img_h   = h;
  endtask

  // header followed by exactly the bytes the packet needs
  task automatic send_packet();
    logic [7:0] hdr;
    hdr[7]   = 1'($urandom_range(0, 1));
    hdr[6:0] = ($urandom_range(0, 1) == 0) ? 7'($urandom_range(0, 7)) : 7'($urandom);
    send_byte(hdr);
    while (!want_header) send_byte(8'($urandom));
  endtask

  task automatic complete_image();
    while (img_pixels_left != 0) begin
      if (rle_on && want_header) send_byte({1'b1, tga_dec_pkg::PKT_COUNT_MASK});
      else send_byte(8'($urandom));
    end
  endtask

  task automatic test_plain_pixels();
    write_regs(1'b0, tga_dec_pkg::BPP_RGB, 16'd1, 16'd2);
    send_byte(8'h00);
    send_byte(8'h7F);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'h01);
    send_byte(8'hFE);
    write_regs(1'b0, tga_dec_pkg::BPP_RGBA, 16'd1, 16'd1);
    send_byte(8'h11);
    send_byte(8'h22);
    send_byte(8'h33);
    send_byte(8'hFF);
    write_regs(1'b0, tga_dec_pkg::BPP_GREY, 16'd1, 16'd1);
    send_byte(8'hFF);
  endtask

  task automatic test_packet_kinds();
    write_regs(1'b1, tga_dec_pkg::BPP_GREY, 16'd3, 16'd2);
    // repeat packet of 128 clipped to the six pixels of the image
    send_byte(8'hFF);
    send_byte(8'h5A);
    // raw packet of two
    send_byte(8'h01);
    send_byte(8'h00);
    send_byte(8'hFF);
    // repeat packet of two
    send_byte(8'h81);
    send_byte(8'h80);
    // raw packet cut short by the end of the image
    send_byte(8'h7F);
    send_byte(8'h01);
    send_byte(8'h02);
  endtask

  task automatic test_odd_settings();
    // zero dimensions act as one pixel, two bytes per pixel acts as one
    write_regs(1'b0, 3'd2, 16'd0, 16'd0);
    send_byte(8'hC3);
    write_regs(1'b0, 3'd7, 16'd0, 16'd0);
    send_byte(8'h01);
    send_byte(8'h02);
    send_byte(8'h04);
    send_byte(8'h08);
  endtask

  task automatic test_random_streams();
    logic        rle;
    logic [2:0]  bpp;
    logic [15:0] w;
    logic [15:0] h;
    int          start;
    for (int phase = 0; phase < 12; phase++) begin
      rle = ($urandom_range(0, 2) != 0);
      case ($urandom_range(0, 3))
        0: bpp = 3'($urandom);
        1: bpp = tga_dec_pkg::BPP_GREY;
        2: bpp = tga_dec_pkg::BPP_RGB;
        default: bpp = tga_dec_pkg::BPP_RGBA;
      endcase
      w = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(0, 300)) : 16'($urandom_range(1, 10));
      h = ($urandom_range(0, 5) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
      write_regs(rle, bpp, w, h);
      steady = (phase == 5);
      start  = bytes_sent;
      while (bytes_sent - start < PHASE_BYTES) begin
        if (rle_on && want_header && $urandom_range(0, 99) < 85) send_packet();
        else send_byte(8'($urandom));
      end
      steady = 1'b0;
    end
  endtask

  task automatic test_max_dimensions();
    // close the open image with one-byte pixels in long repeat packets
    write_regs(1'b1, tga_dec_pkg::BPP_GREY, img_w, img_h);
    complete_image();
    write_regs(1'b1, tga_dec_pkg::BPP_RGBA, 16'hFFFF, 16'hFFFF);
    repeat (10) begin
      send_byte({1'b1, tga_dec_pkg::PKT_COUNT_MASK});
      repeat (4) send_byte(8'($urandom));
    end
    send_byte(8'h01);
    repeat (8) send_byte(8'($urandom));
  endtask

  initial begin
    reset_model();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_plain_pixels();
    test_packet_kinds();
    test_odd_settings();
    test_random_streams();
    test_max_dimensions();
    wait_drained();
    $display("sent %0d stream bytes, checked %0d pixel records", bytes_sent, pixels_checked);
    $display("plain and run-length streams, 1/3/4 byte pixels, odd sizes, clipping, max image");
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("status: fail");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/tga_dec_pkg.sv
rtl/core/tga_dec_front.sv
rtl/core/tga_dec_queue.sv
rtl/core/tga_dec_back.sv
rtl/core/tga_rle_pixel_decoder.sv
dv/tga_rle_pixel_decoder_tb.sv
